@@ hdl/id_bitmap_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// id_bitmap_allocator_defines.svh
// Assertion macros shared by the identifier allocator sources.
// ----------------------------------------------------------------------------
`ifndef ID_BITMAP_ALLOCATOR_DEFINES_SVH
`define ID_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define IDBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define IDBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/idba_pkg.sv @@
// ----------------------------------------------------------------------------
// idba_pkg
// Shared widths, operation codes and types of the identifier allocator.
// ----------------------------------------------------------------------------
package idba_pkg;

    localparam int ID_W   = 8;
    localparam int OP_W   = 3;
    localparam int BIT_W  = 3;
    localparam int BYTE_W = 8;

    // Ids are 8 bits wide, so no more than 32 bytes can ever be addressed.
    localparam int MAX_SCAN_BYTES = 32;

    localparam int DEF_BYTE_COUNT = 32;
    localparam int DEF_INVALID_ID = 0;
    localparam int DEF_PARENT_ID  = 1;
    localparam int DEF_CURRENT_ID = 2;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hff;

    localparam logic [OP_W-1:0] OP_ALLOC_ANY = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_ID  = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE      = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    // Result of the shared byte unit.
    typedef struct packed {
        logic              full;
        logic [BIT_W-1:0]  bit_idx;
        logic              sel_bit;
        logic [BYTE_W-1:0] set_byte;
        logic [BYTE_W-1:0] clr_byte;
    } t_byte_res;

    // Control strobes toward the bitmap store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wipe;
    } t_mem_ctl;

endpackage

@@ hdl/idba_byte_unit.sv @@
// ----------------------------------------------------------------------------
// idba_byte_unit
// Shared byte unit: full test, lowest free bit, bit read, set and clear.
// ----------------------------------------------------------------------------
module idba_byte_unit (
    input  logic [idba_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_find,
    input  logic [idba_pkg::BIT_W-1:0]  i_bit,
    output idba_pkg::t_byte_res         o_res
);
    import idba_pkg::*;

    logic [BIT_W-1:0]  free_bit;
    logic              found;
    logic [BIT_W-1:0]  bit_idx;
    logic [BYTE_W-1:0] mask;

    // Lowest clear bit of the byte.
    always_comb begin
        free_bit = '0;
        found    = 1'b0;
        for (int b = 0; b < BYTE_W; b++) begin
            if (!found && !i_byte[b]) begin
                free_bit = BIT_W'(b);
                found    = 1'b1;
            end
        end
    end

    assign bit_idx = i_find ? free_bit : i_bit;
    assign mask    = BYTE_W'(1) << bit_idx;

    always_comb begin
        o_res.full     = (i_byte == FULL_BYTE);
        o_res.bit_idx  = bit_idx;
        o_res.sel_bit  = i_byte[bit_idx];
        o_res.set_byte = i_byte | mask;
        o_res.clr_byte = i_byte & ~mask;
    end

endmodule

@@ hdl/idba_bitmap.sv @@
// ----------------------------------------------------------------------------
// idba_bitmap
// Used-bit store: one byte per row, registered read, per-row valid bits.
// A row that is not valid reads as its reset pattern (reserved ids set).
// ----------------------------------------------------------------------------
module idba_bitmap #(
    parameter int DEPTH      = idba_pkg::MAX_SCAN_BYTES,
    parameter int ADDR_W     = 5,
    parameter int INVALID_ID = idba_pkg::DEF_INVALID_ID,
    parameter int PARENT_ID  = idba_pkg::DEF_PARENT_ID,
    parameter int CURRENT_ID = idba_pkg::DEF_CURRENT_ID
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  idba_pkg::t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [idba_pkg::BYTE_W-1:0] i_wr_data,
    output logic [idba_pkg::BYTE_W-1:0] o_rd_data
);
    import idba_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [BYTE_W-1:0] r_rd_byte;
    logic              r_rd_valid;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [BYTE_W-1:0] rst_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_byte  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
            r_rd_addr  <= i_rd_addr;
        end
    end

    // Drop every row back to its reset pattern at once on reset or wipe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.wipe) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        logic [ID_W-1:0] id;
        id = '0;
        for (int b = 0; b < BYTE_W; b++) begin
            id = ID_W'({r_rd_addr, BIT_W'(b)});
            rst_byte[b] = (id == ID_W'(INVALID_ID)) || (id == ID_W'(PARENT_ID)) ||
                          (id == ID_W'(CURRENT_ID));
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_byte : rst_byte;

endmodule

@@ hdl/id_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// id_bitmap_allocator
// First-free identifier allocator over a byte-wide used-bit map.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats arrive on s_axis: tuser carries the operation (allocate any,
//   allocate specific, free, query, clear) and tdata the request id. Each beat
//   yields exactly one response beat on m_axis carrying the granted id, ok and
//   is_taken.
//   Path from accept to response valid: allocate-any, and allocate-specific, free
//   and query on an in-range id, pass through the scan state, where allocate-any
//   settles in the first byte k (from 0) with a free bit or at the last byte; clear,
//   unknown, out-of-range requests and a reserved id on allocate-specific or free
//   go straight to the done state. The byte scan reads one map byte per cycle from
//   the store and runs it through the single shared byte unit.
//   The block takes one request at a time: s_axis_tready is high only while
//   idle, so no new beat is taken before the last result leaves the done state.
//   The response sits in an output register; a new request is accepted while
//   it waits. If m_axis_tready stays low, the next finished response waits
//   inside and the block accepts nothing more until the register drains.
//   After reset the map is empty except for the three reserved ids, which
//   read as taken; the map needs no clearing pass.
// ----------------------------------------------------------------------------
module id_bitmap_allocator #(
    parameter int BYTE_COUNT = idba_pkg::DEF_BYTE_COUNT,
    parameter int INVALID_ID = idba_pkg::DEF_INVALID_ID,
    parameter int PARENT_ID  = idba_pkg::DEF_PARENT_ID,
    parameter int CURRENT_ID = idba_pkg::DEF_CURRENT_ID
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] request_id
    input  logic [2:0]  s_axis_tuser,   // [2:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] granted_id, [8] ok, [9] is_taken, zero fill
);
    import idba_pkg::*;

    `include "id_bitmap_allocator_defines.svh"

    localparam int SCAN_BYTES = (BYTE_COUNT < MAX_SCAN_BYTES) ? BYTE_COUNT : MAX_SCAN_BYTES;
    localparam int ADDR_W     = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;
    localparam int ID_LIMIT   = SCAN_BYTES * 8;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(SCAN_BYTES - 1);
    localparam logic [ID_W-1:0]   INV_ID   = ID_W'(INVALID_ID);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_issued, n_issued;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_idx, n_pend_idx;
    logic [ID_W-1:0]   r_res_gid, n_res_gid;
    logic              r_res_ok, n_res_ok;
    logic              r_res_taken, n_res_taken;
    logic              r_out_valid, n_out_valid;
    logic [ID_W-1:0]   r_out_gid, n_out_gid;
    logic              r_out_ok, n_out_ok;
    logic              r_out_taken, n_out_taken;

    t_mem_ctl          mem_ctl;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] wr_data;
    t_byte_res         byte_res;
    logic              in_range;
    logic              reserved;

    idba_bitmap #(
        .DEPTH      (SCAN_BYTES),
        .ADDR_W     (ADDR_W),
        .INVALID_ID (INVALID_ID),
        .PARENT_ID  (PARENT_ID),
        .CURRENT_ID (CURRENT_ID)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (r_idx),
        .i_wr_addr (r_pend_idx),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    idba_byte_unit u_byte_unit (
        .i_byte (rd_data),
        .i_find (r_op == OP_ALLOC_ANY),
        .i_bit  (r_id[BIT_W-1:0]),
        .o_res  (byte_res)
    );

    assign in_range = ({1'b0, s_axis_tdata} < 9'(ID_LIMIT));
    assign reserved = (s_axis_tdata == ID_W'(INVALID_ID)) ||
                      (s_axis_tdata == ID_W'(PARENT_ID)) ||
                      (s_axis_tdata == ID_W'(CURRENT_ID));
    assign wr_data  = (r_op == OP_FREE) ? byte_res.clr_byte : byte_res.set_byte;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_idx       = r_idx;
        n_issued    = r_issued;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_res_gid   = r_res_gid;
        n_res_ok    = r_res_ok;
        n_res_taken = r_res_taken;
        n_out_valid = r_out_valid;
        n_out_gid   = r_out_gid;
        n_out_ok    = r_out_ok;
        n_out_taken = r_out_taken;
        mem_ctl     = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op        = s_axis_tuser;
                    n_id        = s_axis_tdata;
                    n_res_gid   = INV_ID;
                    n_res_ok    = 1'b0;
                    n_res_taken = 1'b0;
                    n_pend      = 1'b0;
                    n_issued    = 1'b0;
                    n_idx       = ADDR_W'(s_axis_tdata >> BIT_W);
                    n_state     = ST_DONE;
                    case (s_axis_tuser)
                        OP_ALLOC_ANY: begin
                            n_idx   = '0;
                            n_state = ST_SCAN;
                        end
                        OP_ALLOC_ID, OP_FREE: begin
                            if (in_range && !reserved) begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_QUERY: begin
                            if (in_range) begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            mem_ctl.wipe = 1'b1;
                            n_res_ok     = 1'b1;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue side: one byte read per cycle, the scan walks upward.
                if (!r_issued) begin
                    mem_ctl.rd_en = 1'b1;
                    n_pend        = 1'b1;
                    n_pend_idx    = r_idx;
                    if (r_op != OP_ALLOC_ANY || r_idx == LAST_IDX) begin
                        n_issued = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_pend = 1'b0;
                end
                // Examine side: the byte read last cycle.
                if (r_pend) begin
                    case (r_op)
                        OP_ALLOC_ANY: begin
                            if (!byte_res.full) begin
                                mem_ctl.wr_en = 1'b1;
                                n_res_gid     = ID_W'({r_pend_idx, byte_res.bit_idx});
                                n_res_ok      = 1'b1;
                                n_state       = ST_DONE;
                            end else if (r_pend_idx == LAST_IDX) begin
                                n_state = ST_DONE;
                            end
                        end
                        OP_ALLOC_ID: begin
                            if (!byte_res.sel_bit) begin
                                mem_ctl.wr_en = 1'b1;
                                n_res_gid     = r_id;
                                n_res_ok      = 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        OP_FREE: begin
                            if (byte_res.sel_bit) begin
                                mem_ctl.wr_en = 1'b1;
                                n_res_gid     = r_id;
                                n_res_ok      = 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        OP_QUERY: begin
                            n_res_gid   = r_id;
                            n_res_ok    = 1'b1;
                            n_res_taken = byte_res.sel_bit;
                            n_state     = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_gid   = r_res_gid;
                    n_out_ok    = r_res_ok;
                    n_out_taken = r_res_taken;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_id        <= n_id;
        r_idx       <= n_idx;
        r_pend_idx  <= n_pend_idx;
        r_res_gid   <= n_res_gid;
        r_res_ok    <= n_res_ok;
        r_res_taken <= n_res_taken;
        r_out_gid   <= n_out_gid;
        r_out_ok    <= n_out_ok;
        r_out_taken <= n_out_taken;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_taken, r_out_ok, r_out_gid};

    `IDBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        r_state != ST_IDLE, "allocator stayed idle after accepting a beat")
    `IDBA_ASSERT_SAME(a_write_only_on_examine, i_clk, i_rst_n, mem_ctl.wr_en,
        (r_state == ST_SCAN) && r_pend, "map write outside a byte examine")
    `IDBA_ASSERT_SAME(a_no_write_on_wipe, i_clk, i_rst_n, mem_ctl.wipe,
        !mem_ctl.wr_en && !mem_ctl.rd_en, "map access during wipe")
    `IDBA_ASSERT_SAME(a_fail_gives_invalid, i_clk, i_rst_n, r_out_valid && !r_out_ok,
        r_out_gid == INV_ID, "failed response without the invalid id")
    `IDBA_ASSERT_SAME(a_taken_needs_ok, i_clk, i_rst_n, r_out_valid && r_out_taken,
        r_out_ok, "taken flag on a failed response")
    `IDBA_ASSERT_NEXT(a_done_drains, i_clk, i_rst_n, (r_state == ST_DONE) && m_axis_tready,
        m_axis_tvalid && (r_state == ST_IDLE), "finished result not moved to output")

endmodule
